@@ rtl/core/tepq_pkg.sv @@
// Package for the timed event priority queue.
// Entry and ordering-key types, status and action codes, size defaults.
// No dependencies.
package tepq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int TIME_W    = 48;
    localparam int KEY_W     = 8;
    localparam int ORD_W     = 5;   // phase and domain, upper bits of the key
    localparam int SEQ_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int COUNT_W   = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PAST  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_POP      = 1'b1;

    // key = {phase[2:0], domain[1:0], kind[2:0]}
    typedef struct packed {
        logic [TIME_W-1:0]    tstamp;
        logic [KEY_W-1:0]     key;
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [ORD_W-1:0]  pd;
        logic [SEQ_W-1:0]  seq;
    } t_ord;

endpackage

@@ rtl/core/tepq_cmp.sv @@
// Shared ordering comparator: time, then phase/domain, then sequence.
// Depends on tepq_pkg.
module tepq_cmp
    import tepq_pkg::*;
(
    input  t_ord i_a,
    input  t_ord i_b,
    output logic o_lt
);

    always_comb begin
        if (i_a.tstamp != i_b.tstamp) begin
            o_lt = (i_a.tstamp < i_b.tstamp);
        end else if (i_a.pd != i_b.pd) begin
            o_lt = (i_a.pd < i_b.pd);
        end else begin
            o_lt = (i_a.seq < i_b.seq);
        end
    end

endmodule

@@ rtl/core/tepq_store.sv @@
// Slot memory: one write port, one read port with registered read data.
// Depends on tepq_pkg.
module tepq_store
    import tepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/timestamped_event_priority_queue_unit.sv @@
// Top level of the timed event priority queue.
// Depends on tepq_pkg, tepq_cmp and tepq_store.
//
// Holds up to QUEUE_DEPTH pending events sorted by time, then phase, then
// domain, then a sequence number handed out at scheduling. A transaction is
// taken when start is high and busy is low; each one produces exactly one
// result, shown for one cycle with o_valid high. The receiver cannot stall:
// the result must be captured in the cycle o_valid is high. Slots live in a
// circular buffer, so a pop only reads the head entry; a schedule walks from
// the tail toward the head with one shared comparator, moving each later
// entry up by one slot per cycle (one memory read and one write per cycle).
// A pop passes through S_POP; a rejected schedule or a schedule into an
// empty queue ends in S_CHECK; a schedule that compares against m pending
// entries then takes one S_WALK step per entry, plus S_PLACE if the event
// lands at the head. busy drops in the result cycle, so the next transaction
// can be taken in that same cycle. Popped fields read zero when
// o_popped_valid is low. No memory clearing pass is needed after reset:
// only occupied slots are ever read.
module timestamped_event_priority_queue_unit
    import tepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [TIME_W-1:0]    i_event_time,
    input  logic [2:0]           i_event_phase,
    input  logic [1:0]           i_event_domain,
    input  logic [2:0]           i_event_kind,
    input  logic [PAYLOAD_W-1:0] i_event_payload,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic                 o_popped_valid,
    output logic [TIME_W-1:0]    o_popped_time,
    output logic [2:0]           o_popped_phase,
    output logic [1:0]           o_popped_domain,
    output logic [2:0]           o_popped_kind,
    output logic [PAYLOAD_W-1:0] o_popped_payload,
    output logic [SEQ_W-1:0]     o_popped_sequence,
    output logic [COUNT_W-1:0]   o_pending_count,
    output logic [TIME_W-1:0]    o_current_time
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;  // past / full check
    localparam logic [2:0] S_WALK  = 3'd2;  // compare and shift one entry
    localparam logic [2:0] S_PLACE = 3'd3;  // new event goes to the head
    localparam logic [2:0] S_POP   = 3'd4;

    logic [2:0]        r_state, n_state;
    t_entry            r_new, n_new;          // event being scheduled
    logic [PTR_W-1:0]  r_j, n_j;              // logical slot under compare
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_now_time, n_now_time;
    logic [ORD_W-1:0]  r_now_pd, n_now_pd;
    logic [SEQ_W-1:0]  r_seq, n_seq;

    // result registers
    logic                 r_valid, n_valid;
    logic [1:0]           r_status, n_status;
    logic                 r_pvalid, n_pvalid;
    t_entry               r_pop, n_pop;
    logic [CNT_W-1:0]     r_pend, n_pend;
    logic [TIME_W-1:0]    r_cur, n_cur;

    // memory and comparator hookup
    logic             w_we;
    logic [PTR_W-1:0] w_wlog, w_rlog;      // logical offsets from head
    logic [PTR_W-1:0] w_waddr, w_raddr;
    t_entry           w_wdata, w_rdata;
    t_ord             w_cmp_a, w_cmp_b;
    logic             w_lt;
    logic [PTR_W:0]   w_wsum, w_rsum, w_hsum;
    logic [CNT_W-1:0] w_cnt_m1;
    logic [PTR_W-1:0] w_head_p1;

    tepq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tepq_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_lt (w_lt)
    );

    // logical offset to physical slot, modulo the depth
    always_comb begin
        w_wsum = {1'b0, r_head} + {1'b0, w_wlog};
        w_rsum = {1'b0, r_head} + {1'b0, w_rlog};
        w_hsum = {1'b0, r_head} + (PTR_W+1)'(1);
        if (w_wsum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            w_wsum = w_wsum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        if (w_rsum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            w_rsum = w_rsum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        if (w_hsum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            w_hsum = w_hsum - (PTR_W+1)'(QUEUE_DEPTH);
        end
    end

    assign w_waddr   = w_wsum[PTR_W-1:0];
    assign w_raddr   = w_rsum[PTR_W-1:0];
    assign w_head_p1 = w_hsum[PTR_W-1:0];
    assign w_cnt_m1  = r_cnt - CNT_W'(1);

    // comparator operands: against "now" for the past check, else against
    // the entry just read during the walk
    always_comb begin
        w_cmp_a.tstamp = r_new.tstamp;
        w_cmp_a.pd     = r_new.key[KEY_W-1:KEY_W-ORD_W];
        if (r_state == S_CHECK) begin
            w_cmp_a.seq    = '0;
            w_cmp_b.tstamp = r_now_time;
            w_cmp_b.pd     = r_now_pd;
            w_cmp_b.seq    = '0;
        end else begin
            w_cmp_a.seq    = r_new.seq;
            w_cmp_b.tstamp = w_rdata.tstamp;
            w_cmp_b.pd     = w_rdata.key[KEY_W-1:KEY_W-ORD_W];
            w_cmp_b.seq    = w_rdata.seq;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_new      = r_new;
        n_j        = r_j;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_now_time = r_now_time;
        n_now_pd   = r_now_pd;
        n_seq      = r_seq;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_pvalid   = r_pvalid;
        n_pop      = r_pop;
        n_pend     = r_pend;
        n_cur      = r_cur;
        w_we       = 1'b0;
        w_wlog     = r_j + PTR_W'(1);
        w_wdata    = r_new;
        w_rlog     = '0;

        unique case (r_state)
            S_IDLE: begin
                // read address parked on the head so a pop finds it ready
                if (start) begin
                    n_new.tstamp  = i_event_time;
                    n_new.key     = {i_event_phase, i_event_domain, i_event_kind};
                    n_new.seq     = r_seq;
                    n_new.payload = i_event_payload;
                    n_state = (i_action == ACT_POP) ? S_POP : S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_lt) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_PAST;
                    n_pvalid = 1'b0;
                    n_pop    = '0;
                    n_pend   = r_cnt;
                    n_cur    = r_now_time;
                end else if (r_cnt == CNT_W'(QUEUE_DEPTH)) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_FULL;
                    n_pvalid = 1'b0;
                    n_pop    = '0;
                    n_pend   = r_cnt;
                    n_cur    = r_now_time;
                end else if (r_cnt == '0) begin
                    w_we     = 1'b1;
                    w_wlog   = '0;
                    n_seq    = r_seq + SEQ_W'(1);
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pvalid = 1'b0;
                    n_pop    = '0;
                    n_pend   = r_cnt + CNT_W'(1);
                    n_cur    = r_now_time;
                end else begin
                    w_rlog  = w_cnt_m1[PTR_W-1:0];
                    n_j     = w_cnt_m1[PTR_W-1:0];
                    n_seq   = r_seq + SEQ_W'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                w_we = 1'b1;
                if (w_lt) begin
                    // new event orders first: move this entry up one slot
                    w_wdata = w_rdata;
                    if (r_j == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        w_rlog = r_j - PTR_W'(1);
                        n_j    = r_j - PTR_W'(1);
                    end
                end else begin
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pvalid = 1'b0;
                    n_pop    = '0;
                    n_pend   = r_cnt + CNT_W'(1);
                    n_cur    = r_now_time;
                end
            end
            S_PLACE: begin
                w_we     = 1'b1;
                w_wlog   = r_j;
                n_cnt    = r_cnt + CNT_W'(1);
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_pvalid = 1'b0;
                n_pop    = '0;
                n_pend   = r_cnt + CNT_W'(1);
                n_cur    = r_now_time;
            end
            S_POP: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                if (r_cnt == '0) begin
                    n_status = ST_EMPTY;
                    n_pvalid = 1'b0;
                    n_pop    = '0;
                    n_pend   = r_cnt;
                    n_cur    = r_now_time;
                end else begin
                    n_status   = ST_OK;
                    n_pvalid   = 1'b1;
                    n_pop      = w_rdata;
                    n_head     = w_head_p1;
                    n_cnt      = w_cnt_m1;
                    n_now_time = w_rdata.tstamp;
                    n_now_pd   = w_rdata.key[KEY_W-1:KEY_W-ORD_W];
                    n_pend     = w_cnt_m1;
                    n_cur      = w_rdata.tstamp;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_cnt      <= '0;
            r_now_time <= '0;
            r_now_pd   <= '0;
            r_seq      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_cnt      <= n_cnt;
            r_now_time <= n_now_time;
            r_now_pd   <= n_now_pd;
            r_seq      <= n_seq;
            r_valid    <= n_valid;
        end
    end

    // payload and result data
    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_j      <= n_j;
        r_status <= n_status;
        r_pvalid <= n_pvalid;
        r_pop    <= n_pop;
        r_pend   <= n_pend;
        r_cur    <= n_cur;
    end

    logic [CNT_W+COUNT_W-1:0] w_pend_ext;
    assign w_pend_ext = {{COUNT_W{1'b0}}, r_pend};

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_popped_valid    = r_pvalid;
    assign o_popped_time     = r_pop.tstamp;
    assign o_popped_phase    = r_pop.key[7:5];
    assign o_popped_domain   = r_pop.key[4:3];
    assign o_popped_kind     = r_pop.key[2:0];
    assign o_popped_payload  = r_pop.payload;
    assign o_popped_sequence = r_pop.seq;
    assign o_pending_count   = w_pend_ext[COUNT_W-1:0];
    assign o_current_time    = r_cur;

    // a taken transaction keeps the sequencer busy in the following cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("sequencer did not leave idle after a transaction");

    // result cycle coincides with the sequencer back in idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer busy");

    // occupancy moves by at most one per cycle and never passes the depth
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ((r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + CNT_W'(1) ||
                      r_cnt == $past(r_cnt) - CNT_W'(1)) &&
                     r_cnt <= CNT_W'(QUEUE_DEPTH)))
        else $error("occupancy count jumped or overflowed");

endmodule
